FILE: hdl/text_console_cursor_scroll_defines.svh
// ---------------------------------------------------------------------------
// text console assertion macros
// shared concurrent assertion forms for the console modules
// ---------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_DEFINES_SVH

// condition holds at every edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("console assertion failed");

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("console assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("console assertion failed");

`endif

FILE: hdl/tcc_pkg.sv
// ---------------------------------------------------------------------------
// tcc_pkg
// shared codes, constants and controller/datapath interface types
// ---------------------------------------------------------------------------
package tcc_pkg;

    localparam logic [1:0] MODE_PUT   = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] SPACE_CODE   = 8'd32;
    localparam logic [7:0] RESET_COLOR  = 8'd7;

    // commands from controller to datapath
    typedef struct packed {
        logic load_item;
        logic put;
        logic read_cell;
        logic home;
        logic copy_prime;
        logic copy_step;
        logic fill_step;
        logic fill_reset;
        logic finish;
    } tcc_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic [1:0] mode;
        logic       scroll_needed;
        logic       copy_last;
        logic       sweep_last;
    } tcc_status_t;

endpackage

FILE: hdl/text_console_cursor_scroll.sv
// put and read: the accepted word passes the EXEC and RESP sequencer steps before done is strobed;
//   busy holds off a next start until then, and the next start is taken in the done cycle
// a put that scrolls adds the COPY_PRIME, COPY and FILL_ROW steps (one store cell copied or blanked a cycle)
// clear adds the CLEAR step, one cell blanked per cycle through the single write port
// after reset busy stays high while the store is blanked
// done is a one-cycle strobe; the receiver cannot stall it
// ---------------------------------------------------------------------------
// text_console_cursor_scroll
// character-cell text console with cursor, line wrap, scroll and cell read
// ---------------------------------------------------------------------------
module text_console_cursor_scroll
    import tcc_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
)(
    input  logic        clk,
    input  logic        rst_n,
    // attribute register write
    input  logic        text_color_we,
    input  logic [7:0]  text_color,
    // command word, taken when start is high and busy is low
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  mode,
    input  logic [7:0]  char_code,
    input  logic [10:0] cell_index,
    // result word, valid for the single cycle done is high
    output logic        done,
    output logic [7:0]  read_char,
    output logic [7:0]  read_color,
    output logic [4:0]  cursor_row,
    output logic [6:0]  cursor_col,
    output logic        scrolled
);

    tcc_cmd_t    cmd;
    tcc_status_t status;

    // sequencer: decodes the latched word and walks the store for scroll and clear
    tcc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // datapath: screen store (one write, one registered read per cycle),
    // cursor with a running row base so no multiply is needed for the cell address
    tcc_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .text_color_we (text_color_we),
        .text_color    (text_color),
        .mode          (mode),
        .char_code     (char_code),
        .cell_index    (cell_index),
        .cmd           (cmd),
        .status        (status),
        .read_char     (read_char),
        .read_color    (read_color),
        .cursor_row    (cursor_row),
        .cursor_col    (cursor_col),
        .scrolled      (scrolled)
    );

endmodule

FILE: hdl/tcc_datapath.sv
// ---------------------------------------------------------------------------
// tcc_datapath
// screen store, cursor registers, sweep pointers and result registers
// ---------------------------------------------------------------------------
`include "text_console_cursor_scroll_defines.svh"

module tcc_datapath
    import tcc_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        text_color_we,
    input  logic [7:0]  text_color,
    input  logic [1:0]  mode,
    input  logic [7:0]  char_code,
    input  logic [10:0] cell_index,
    input  tcc_cmd_t    cmd,
    output tcc_status_t status,
    output logic [7:0]  read_char,
    output logic [7:0]  read_color,
    output logic [4:0]  cursor_row,
    output logic [6:0]  cursor_col,
    output logic        scrolled
);

    localparam int CELLS      = COLUMNS * ROWS;
    localparam int COPY_CELLS = (ROWS - 1) * COLUMNS;
    localparam int AW         = $clog2(CELLS);
    localparam int PW         = $clog2(CELLS + 1);
    localparam int RW         = $clog2(ROWS);
    localparam int CW         = $clog2(COLUMNS);

    logic [15:0]   mem [CELLS];

    logic [7:0]    color_reg;
    logic [1:0]    mode_reg;
    logic [7:0]    char_reg;
    logic [10:0]   index_reg;
    logic [RW-1:0] row_reg;
    logic [CW-1:0] col_reg;
    logic [AW-1:0] row_base_reg;
    logic [AW-1:0] sweep_ptr_reg;
    logic [PW-1:0] src_ptr_reg;
    logic          pend_scroll_reg;
    logic [15:0]   rd_data_reg;
    logic [7:0]    read_char_reg;
    logic [7:0]    read_color_reg;
    logic          scrolled_reg;

    logic [AW-1:0] cursor_addr;
    logic          col_last;
    logic          row_last;
    logic          is_newline;
    logic          scroll_needed;
    logic          index_ok;
    logic [15:0]   blank_cell;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [15:0]   wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;

    assign cursor_addr   = row_base_reg + AW'(col_reg);
    assign col_last      = (col_reg == CW'(COLUMNS - 1));
    assign row_last      = (row_reg == RW'(ROWS - 1));
    assign is_newline    = (char_reg == NEWLINE_CODE);
    assign scroll_needed = row_last && (is_newline || col_last);
    assign index_ok      = (32'(index_reg) < 32'(CELLS));
    assign blank_cell    = {(cmd.fill_reset ? RESET_COLOR : color_reg), SPACE_CODE};

    assign status.mode          = mode_reg;
    assign status.scroll_needed = scroll_needed;
    assign status.copy_last     = (sweep_ptr_reg == AW'(COPY_CELLS - 1));
    assign status.sweep_last    = (sweep_ptr_reg == AW'(CELLS - 1));

    // write port select
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = sweep_ptr_reg;
        wr_data = blank_cell;
        if (cmd.put && !is_newline)
        begin
            wr_en   = 1'b1;
            wr_addr = cursor_addr;
            wr_data = {color_reg, char_reg};
        end
        else if (cmd.copy_step)
        begin
            wr_en   = 1'b1;
            wr_data = rd_data_reg;
        end
        else if (cmd.fill_step)
        begin
            wr_en = 1'b1;
        end
    end

    // read port select
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = AW'(index_reg);
        if (cmd.copy_prime || cmd.copy_step)
        begin
            rd_en   = (32'(src_ptr_reg) < 32'(CELLS));
            rd_addr = src_ptr_reg[AW-1:0];
        end
        else if (cmd.read_cell)
        begin
            rd_en = index_ok;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // item and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            mode_reg  <= mode;
            char_reg  <= char_code;
            index_reg <= cell_index;
        end
        if (cmd.finish)
        begin
            if (mode_reg == MODE_READ && index_ok)
            begin
                read_char_reg  <= rd_data_reg[7:0];
                read_color_reg <= rd_data_reg[15:8];
            end
            else
            begin
                read_char_reg  <= 8'd0;
                read_color_reg <= 8'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_reg       <= RESET_COLOR;
            row_reg         <= '0;
            col_reg         <= '0;
            row_base_reg    <= '0;
            sweep_ptr_reg   <= '0;
            src_ptr_reg     <= '0;
            pend_scroll_reg <= 1'b0;
            scrolled_reg    <= 1'b0;
        end
        else
        begin
            if (text_color_we)
            begin
                color_reg <= text_color;
            end
            if (cmd.load_item)
            begin
                pend_scroll_reg <= 1'b0;
            end
            if (cmd.home)
            begin
                row_reg       <= '0;
                col_reg       <= '0;
                row_base_reg  <= '0;
                sweep_ptr_reg <= '0;
            end
            if (cmd.put)
            begin
                sweep_ptr_reg   <= '0;
                src_ptr_reg     <= PW'(COLUMNS);
                pend_scroll_reg <= scroll_needed;
                if (is_newline || col_last)
                begin
                    col_reg <= '0;
                    if (!row_last)
                    begin
                        row_reg      <= row_reg + 1'b1;
                        row_base_reg <= row_base_reg + AW'(COLUMNS);
                    end
                end
                else
                begin
                    col_reg <= col_reg + 1'b1;
                end
            end
            if (cmd.copy_prime || cmd.copy_step)
            begin
                src_ptr_reg <= src_ptr_reg + 1'b1;
            end
            if (cmd.copy_step || cmd.fill_step)
            begin
                sweep_ptr_reg <= sweep_ptr_reg + 1'b1;
            end
            if (cmd.finish)
            begin
                scrolled_reg <= pend_scroll_reg;
            end
        end
    end

    assign read_char  = read_char_reg;
    assign read_color = read_color_reg;
    assign cursor_row = 5'(row_reg);
    assign cursor_col = 7'(col_reg);
    assign scrolled   = scrolled_reg;

    `ASSERT_ALWAYS(a_row_range, clk, rst_n, 32'(row_reg) < 32'(ROWS))
    `ASSERT_ALWAYS(a_col_range, clk, rst_n, 32'(col_reg) < 32'(COLUMNS))
    `ASSERT_ALWAYS(a_row_base, clk, rst_n, 32'(row_base_reg) == 32'(row_reg) * 32'(COLUMNS))

endmodule

FILE: hdl/tcc_ctrl.sv
// ---------------------------------------------------------------------------
// tcc_ctrl
// sequencer for put, read, clear, scroll copy and reset clearing
// ---------------------------------------------------------------------------
`include "text_console_cursor_scroll_defines.svh"

module tcc_ctrl
    import tcc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  tcc_status_t status,
    output tcc_cmd_t    cmd,
    output logic        busy,
    output logic        done
);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_COPY_PRIME,
        S_COPY,
        S_FILL_ROW,
        S_CLEAR,
        S_RESP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   done_next;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_INIT:
            begin
                cmd.fill_step  = 1'b1;
                cmd.fill_reset = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (status.mode)
                    MODE_PUT:
                    begin
                        cmd.put    = 1'b1;
                        state_next = status.scroll_needed ? S_COPY_PRIME : S_RESP;
                    end
                    MODE_READ:
                    begin
                        cmd.read_cell = 1'b1;
                        state_next    = S_RESP;
                    end
                    MODE_CLEAR:
                    begin
                        cmd.home   = 1'b1;
                        state_next = S_CLEAR;
                    end
                    default:
                    begin
                        state_next = S_RESP;
                    end
                endcase
            end
            S_COPY_PRIME:
            begin
                cmd.copy_prime = 1'b1;
                state_next     = S_COPY;
            end
            S_COPY:
            begin
                cmd.copy_step = 1'b1;
                if (status.copy_last)
                begin
                    state_next = S_FILL_ROW;
                end
            end
            S_FILL_ROW, S_CLEAR:
            begin
                cmd.fill_step = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                cmd.finish = 1'b1;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

    `ASSERT_NEXT(a_done_single, clk, rst_n, done, !done)
    `ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    `ASSERT_SAME(a_done_idle, clk, rst_n, done, !busy)

endmodule

FILE: verif/tb_text_console_cursor_scroll.sv
// ---------------------------------------------------------------------------
// tb_text_console_cursor_scroll
// self-checking bench for the text console: a predictor keeps its own screen
// store, cursor and attribute, and every done word is checked field by field
// ---------------------------------------------------------------------------
module tb_text_console_cursor_scroll
    import tcc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SCREEN_COLS  = 80;
    localparam int SCREEN_ROWS  = 25;
    localparam int SCREEN_CELLS = SCREEN_COLS * SCREEN_ROWS;
    localparam int INDEX_MAX    = 2047;

    // mode code the block has no operation for
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // one command word as the bench sees it
    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  ch;
        logic [10:0] index;
    } console_word_t;

    // one result word
    typedef struct packed {
        logic [7:0] rd_char;
        logic [7:0] rd_color;
        logic [4:0] row;
        logic [6:0] col;
        logic       scrolled;
    } console_result_t;

    logic        clk;
    logic        rst_n;
    logic        text_color_we;
    logic [7:0]  text_color;
    logic        start;
    logic        busy;
    logic [1:0]  mode;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
    logic        done;
    logic [7:0]  read_char;
    logic [7:0]  read_color;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
    logic        scrolled;

    // predictor state: screen store, cursor and attribute register
    logic [15:0]     screen_model [0:SCREEN_CELLS-1];
    int unsigned     cur_row;
    int unsigned     cur_col;
    logic [7:0]      attr_model;

    // results still owed by the block, oldest first
    console_result_t expected_results [$];

    int              mismatches = 0;
    int              idle_pct   = 0;

    text_console_cursor_scroll #(
        .COLUMNS (SCREEN_COLS),
        .ROWS    (SCREEN_ROWS)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .text_color_we (text_color_we),
        .text_color    (text_color),
        .start         (start),
        .busy          (busy),
        .mode          (mode),
        .char_code     (char_code),
        .cell_index    (cell_index),
        .done          (done),
        .read_char     (read_char),
        .read_color    (read_color),
        .cursor_row    (cursor_row),
        .cursor_col    (cursor_col),
        .scrolled      (scrolled)
    );

    // 100 MHz clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit, far above the slowest legal run: every word a full scroll
    // plus the longest sender gap, about 21 ms in total
    initial
    begin
        #100_000_000;
        $display("text_console_cursor_scroll verification failed");
        $finish;
    end

    // ---------------------------------------------------------------------
    // reporting
    // ---------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
    endtask

    // ---------------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------------

    // every cell to a space in the given attribute, cursor home
    function automatic void blank_screen_model(input logic [7:0] attr);
        for (int i = 0; i < SCREEN_CELLS; i++)
            screen_model[i] = {attr, SPACE_CODE};
        cur_row = 0;
        cur_col = 0;
    endfunction

    // apply one accepted word to the predictor and return what it owes
    function automatic console_result_t apply_console_word(input console_word_t w);
        console_result_t r;
        r = '0;
        case (w.mode)
            MODE_PUT:
            begin
                if (w.ch == NEWLINE_CODE)
                begin
                    cur_col = 0;
                    cur_row++;
                end
                else
                begin
                    screen_model[cur_row * SCREEN_COLS + cur_col] = {attr_model, w.ch};
                    cur_col++;
                end
                // wrap at end of line
                if (cur_col >= SCREEN_COLS)
                begin
                    cur_col = 0;
                    cur_row++;
                end
                // past the bottom: shift lines up, blank the last one
                if (cur_row >= SCREEN_ROWS)
                begin
                    for (int i = 0; i < SCREEN_CELLS - SCREEN_COLS; i++)
                        screen_model[i] = screen_model[i + SCREEN_COLS];
                    for (int i = SCREEN_CELLS - SCREEN_COLS; i < SCREEN_CELLS; i++)
                        screen_model[i] = {attr_model, SPACE_CODE};
                    cur_row    = SCREEN_ROWS - 1;
                    r.scrolled = 1'b1;
                end
            end
            MODE_READ:
            begin
                // out-of-range index reads as zero
                if (int'(w.index) < SCREEN_CELLS)
                begin
                    r.rd_char  = screen_model[w.index][7:0];
                    r.rd_color = screen_model[w.index][15:8];
                end
            end
            MODE_CLEAR:
                blank_screen_model(attr_model);
            default:
                ;   // unused mode leaves everything alone
        endcase
        r.row = cur_row[4:0];
        r.col = cur_col[6:0];
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // result checker: done is a one-cycle strobe, sampled at the edge
    // ---------------------------------------------------------------------

    always @(posedge clk)
    begin : result_check
        console_result_t want;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
                report_mismatch("result word with nothing expected");
            else
            begin
                want = expected_results.pop_front();
                check_field("read_char",  read_char,  want.rd_char);
                check_field("read_color", read_color, want.rd_color);
                check_field("cursor_row", cursor_row, want.row);
                check_field("cursor_col", cursor_col, want.col);
                check_field("scrolled",   scrolled,   want.scrolled);
            end
        end
    end

    // ---------------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------------

    function automatic logic [10:0] any_index();
        return 11'($urandom_range(0, INDEX_MAX));
    endfunction

    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // read target: mostly near the cursor, some anywhere, some off the screen
    function automatic logic [10:0] read_target();
        int          pick;
        int unsigned row;
        pick = $urandom_range(0, 99);
        if (pick < 50)
        begin
            row = (cur_row > 0) ? $urandom_range(cur_row - 1, cur_row) : 0;
            return 11'(row * SCREEN_COLS + $urandom_range(0, SCREEN_COLS - 1));
        end
        else if (pick < 90)
            return 11'($urandom_range(0, SCREEN_CELLS - 1));
        else
            return 11'($urandom_range(SCREEN_CELLS, INDEX_MAX));
    endfunction

    // offer one word, hold it until the block takes it, log what it owes;
    // start stays high afterwards so back-to-back words need no gap
    task automatic send_word(input logic [1:0] m, input logic [7:0] ch,
                             input logic [10:0] idx);
        console_word_t w;
        // random sender gap before the word
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        w.mode  = m;
        w.ch    = ch;
        w.index = idx;
        start      <= 1'b1;
        mode       <= m;
        char_code  <= ch;
        cell_index <= idx;
        @(posedge clk);
        // busy as seen at this edge decides acceptance
        while (busy)
            @(posedge clk);
        expected_results.push_back(apply_console_word(w));
    endtask

    // drop start and wait for every owed word and for the block to go quiet
    task automatic wait_idle();
        start <= 1'b0;
        while (expected_results.size() != 0 || busy)
            @(posedge clk);
    endtask

    // attribute write, only with the block quiet
    task automatic write_text_color(input logic [7:0] value);
        wait_idle();
        text_color_we <= 1'b1;
        text_color    <= value;
        @(posedge clk);
        text_color_we <= 1'b0;
        attr_model     = value;
    endtask

    // ---------------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------------

    // store after the reset clearing pass, including reads off the screen
    task automatic test_reset_contents();
        send_word(MODE_READ, any_byte(), 11'd0);
        send_word(MODE_READ, any_byte(), 11'(SCREEN_CELLS - 1));
        send_word(MODE_READ, any_byte(), 11'(SCREEN_CELLS));
        send_word(MODE_READ, any_byte(), 11'(INDEX_MAX));
    endtask

    // byte extremes with attribute extremes, newline, read back
    task automatic test_put_and_color();
        write_text_color(8'h00);
        send_word(MODE_PUT, 8'h00, 11'(INDEX_MAX));
        write_text_color(8'hFF);
        send_word(MODE_PUT, 8'hFF, 11'd0);
        send_word(MODE_PUT, NEWLINE_CODE, any_index());
        write_text_color(8'hA5);
        send_word(MODE_PUT, 8'h55, any_index());
        send_word(MODE_PUT, 8'hAA, any_index());
        send_word(MODE_READ, any_byte(), 11'd0);
        send_word(MODE_READ, any_byte(), 11'd1);
        send_word(MODE_READ, any_byte(), 11'(SCREEN_COLS));
        send_word(MODE_READ, any_byte(), 11'(SCREEN_COLS + 1));
    endtask

    // unused mode must change nothing and report the cursor as it is
    task automatic test_unused_mode();
        send_word(MODE_UNUSED, 8'hFF, 11'(INDEX_MAX));
        send_word(MODE_UNUSED, NEWLINE_CODE, 11'd0);
    endtask

    // clear fills with the current attribute and homes the cursor
    task automatic test_clear_screen();
        write_text_color(8'h5A);
        send_word(MODE_CLEAR, any_byte(), any_index());
        send_word(MODE_READ, any_byte(), 11'd0);
        send_word(MODE_READ, any_byte(), 11'(SCREEN_CELLS - 1));
    endtask

    // runs of text lines, newline bursts and reads so the cursor walks the
    // whole screen, wraps and scrolls; clears, unused modes and noise mixed in
    task automatic test_random_traffic(input int pct, input logic [7:0] color,
                                       input int n_words);
        int         sent;
        int         pick;
        int         run_len;
        logic [1:0] m;
        write_text_color(color);
        idle_pct = pct;
        sent     = 0;
        while (sent < n_words)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                // line of text, usually closed by a newline
                run_len = $urandom_range(1, 60);
                repeat (run_len)
                    send_word(MODE_PUT, any_byte(), any_index());
                sent += run_len;
                if ($urandom_range(0, 9) < 7)
                begin
                    send_word(MODE_PUT, NEWLINE_CODE, any_index());
                    sent++;
                end
            end
            else if (pick < 60)
            begin
                // newline burst, pushes the cursor toward the bottom
                run_len = $urandom_range(1, 26);
                repeat (run_len)
                    send_word(MODE_PUT, NEWLINE_CODE, any_index());
                sent += run_len;
            end
            else if (pick < 85)
            begin
                run_len = $urandom_range(1, 12);
                repeat (run_len)
                    send_word(MODE_READ, any_byte(), read_target());
                sent += run_len;
            end
            else if (pick < 89)
            begin
                send_word(MODE_CLEAR, any_byte(), any_index());
                sent++;
            end
            else if (pick < 93)
                send_word(MODE_UNUSED, any_byte(), any_index());
            else
            begin
                // noise: any mode, any fields
                m = 2'($urandom_range(0, 3));
                send_word(m, any_byte(), any_index());
                if (m != MODE_UNUSED)
                    sent++;
            end
        end
    endtask

    // ---------------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------------

    initial
    begin
        rst_n         <= 1'b0;
        start         <= 1'b0;
        mode          <= MODE_PUT;
        char_code     <= 8'd0;
        cell_index    <= 11'd0;
        text_color_we <= 1'b0;
        text_color    <= 8'd0;
        attr_model     = RESET_COLOR;
        blank_screen_model(RESET_COLOR);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed part, no sender gaps
        idle_pct = 0;
        test_reset_contents();
        test_put_and_color();
        test_unused_mode();
        test_clear_screen();

        // random part in idling phases; the receiver cannot stall, so its
        // phase runs the sender freely
        test_random_traffic(0,  RESET_COLOR, 250);
        test_random_traffic(75, 8'hFF, 250);
        test_random_traffic(0,  8'h00, 250);
        test_random_traffic(23, 8'($urandom_range(1, 254)), 250);

        // drain, then give a stray word time to show up
        wait_idle();
        repeat (SCREEN_CELLS + 16) @(posedge clk);

        if (mismatches == 0)
            $display("text_console_cursor_scroll verification clean");
        else
            $display("text_console_cursor_scroll verification failed");
        $finish;
    end

endmodule
